// ----- rtl/core/pidaw_pkg.sv -----
`default_nettype none
package pidaw_pkg;

	localparam int DATA_W    = 16;
	localparam int FRAC_BITS = 8;
	localparam int ERR_W     = DATA_W + 1;
	localparam int BOUND_W   = DATA_W - 1;
	localparam int INDEX_W   = 4;

	typedef enum logic [INDEX_W-1:0] {
		REG_TARGET     = 4'd0,
		REG_PROP_GAIN  = 4'd1,
		REG_INTEG_GAIN = 4'd2,
		REG_DERIV_GAIN = 4'd3,
		REG_FLOOR      = 4'd4,
		REG_CEILING    = 4'd5,
		REG_WINDUP     = 4'd6,
		REG_RUN_ENABLE = 4'd7
	} reg_idx_t;

	localparam logic signed [DATA_W-1:0] TARGET_RST     = 16'sd0;
	localparam logic signed [DATA_W-1:0] PROP_GAIN_RST  = 16'sd256;
	localparam logic signed [DATA_W-1:0] INTEG_GAIN_RST = 16'sd0;
	localparam logic signed [DATA_W-1:0] DERIV_GAIN_RST = 16'sd0;
	localparam logic signed [DATA_W-1:0] FLOOR_RST      = -16'sd25600;
	localparam logic signed [DATA_W-1:0] CEILING_RST    = 16'sd25600;
	localparam logic [BOUND_W-1:0]       WINDUP_RST     = 15'd2560;

	typedef struct packed {
		logic signed [DATA_W-1:0] target_value;
		logic signed [DATA_W-1:0] prop_gain;
		logic signed [DATA_W-1:0] integ_gain;
		logic signed [DATA_W-1:0] deriv_gain;
		logic signed [DATA_W-1:0] drive_floor;
		logic signed [DATA_W-1:0] drive_ceiling;
		logic [BOUND_W-1:0]       windup_bound;
		logic                     run_enable;
		logic                     clear_state;
	} cfg_t;

endpackage
`default_nettype wire

// ----- rtl/core/pidaw_cfg_regs.sv -----
`default_nettype none
module pidaw_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pidaw_pkg::INDEX_W-1:0]       cfg_index,
	input  wire logic [pidaw_pkg::DATA_W-1:0]        cfg_data,
	output pidaw_pkg::cfg_t                          cfg
);

	pidaw_pkg::cfg_t cfg_q;
	logic            wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_value  <= pidaw_pkg::TARGET_RST;
			cfg_q.prop_gain     <= pidaw_pkg::PROP_GAIN_RST;
			cfg_q.integ_gain    <= pidaw_pkg::INTEG_GAIN_RST;
			cfg_q.deriv_gain    <= pidaw_pkg::DERIV_GAIN_RST;
			cfg_q.drive_floor   <= pidaw_pkg::FLOOR_RST;
			cfg_q.drive_ceiling <= pidaw_pkg::CEILING_RST;
			cfg_q.windup_bound  <= pidaw_pkg::WINDUP_RST;
			cfg_q.run_enable    <= 1'b0;
			cfg_q.clear_state   <= 1'b0;
		end else begin
			// Every in-range write also restarts the integral and the error history.
			cfg_q.clear_state <= wr && (cfg_index <= pidaw_pkg::REG_RUN_ENABLE);
			if (wr) begin
				case (pidaw_pkg::reg_idx_t'(cfg_index))
					pidaw_pkg::REG_TARGET:     cfg_q.target_value  <= $signed(cfg_data);
					pidaw_pkg::REG_PROP_GAIN:  cfg_q.prop_gain     <= $signed(cfg_data);
					pidaw_pkg::REG_INTEG_GAIN: cfg_q.integ_gain    <= $signed(cfg_data);
					pidaw_pkg::REG_DERIV_GAIN: cfg_q.deriv_gain    <= $signed(cfg_data);
					pidaw_pkg::REG_FLOOR:      cfg_q.drive_floor   <= $signed(cfg_data);
					pidaw_pkg::REG_CEILING:    cfg_q.drive_ceiling <= $signed(cfg_data);
					pidaw_pkg::REG_WINDUP:
						cfg_q.windup_bound <= cfg_data[pidaw_pkg::BOUND_W-1:0];
					pidaw_pkg::REG_RUN_ENABLE: cfg_q.run_enable    <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/pid_controller_antiwindup_top.sv -----
`default_nettype none
// PID controller with a clamped error integral, signed Q8.8 throughout. One measurement
// transaction can be accepted every clock cycle unless back-pressure fills the pipeline;
// it passes through the input register, integral update, gain multipliers, then sum and
// saturation into the output register, and each pipeline stage holds its data
// independently, so a stalled output only backs up the stages behind it. The integral add
// and clamp is combinational; the integral and the previous error are the only values
// carried from sample to sample. Configuration writes are taken every cycle (cfg_ready is
// always high); any in-range write clears the integral and the previous error, and writes
// to indexes above 7 are ignored. While run_enable is 0 each sample returns drive 0,
// control_error 0 and not_ready 1 and leaves the controller state alone.
module pid_controller_antiwindup_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [pidaw_pkg::INDEX_W-1:0]         cfg_index,
	input  wire logic [pidaw_pkg::DATA_W-1:0]          cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [pidaw_pkg::DATA_W-1:0]   measurement,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [pidaw_pkg::DATA_W-1:0]        drive,
	output logic signed [pidaw_pkg::ERR_W-1:0]         control_error,
	output logic                                       not_ready
);

	localparam int DIFF_W = pidaw_pkg::ERR_W + 1;
	localparam int PP_W   = pidaw_pkg::DATA_W + pidaw_pkg::ERR_W;
	localparam int PI_W   = 2 * pidaw_pkg::DATA_W;
	localparam int PD_W   = pidaw_pkg::DATA_W + DIFF_W;
	localparam int SUM_W  = PD_W + 2;
	localparam int SH_W   = SUM_W - pidaw_pkg::FRAC_BITS;

	pidaw_pkg::cfg_t cfg;

	pidaw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage valids and per-stage advance enables.
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic adv_out, adv_s3, adv_s2, adv_s1;

	assign adv_out  = !out_valid_q || out_ready;
	assign adv_s3   = !v_s3 || adv_out;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	// Stage 1: captured sample.
	logic signed [pidaw_pkg::DATA_W-1:0] meas_s1;

	// Controller state.
	logic signed [pidaw_pkg::DATA_W-1:0] integral_q;
	logic signed [pidaw_pkg::ERR_W-1:0]  prev_err_q;

	logic signed [pidaw_pkg::ERR_W-1:0] err;
	logic signed [DIFF_W-1:0]           integ_raw;
	logic signed [DIFF_W-1:0]           bound;
	logic signed [DIFF_W-1:0]           integ_clamped;
	logic signed [DIFF_W-1:0]           diff;

	always_comb begin
		err = pidaw_pkg::ERR_W'(cfg.target_value) - pidaw_pkg::ERR_W'(meas_s1);
		integ_raw = DIFF_W'(integral_q) + DIFF_W'(err);
		bound = $signed({3'b000, cfg.windup_bound});
		if (integ_raw > bound) begin
			integ_clamped = bound;
		end else if (integ_raw < -bound) begin
			integ_clamped = -bound;
		end else begin
			integ_clamped = integ_raw;
		end
		diff = DIFF_W'(err) - DIFF_W'(prev_err_q);
	end

	logic step_s1;
	assign step_s1 = v_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_err_q <= '0;
		end else if (cfg.clear_state) begin
			integral_q <= '0;
			prev_err_q <= '0;
		end else if (step_s1 && cfg.run_enable) begin
			integral_q <= integ_clamped[pidaw_pkg::DATA_W-1:0];
			prev_err_q <= err;
		end
	end

	// Stage 2: error terms.
	logic signed [pidaw_pkg::ERR_W-1:0]  err_s2;
	logic signed [pidaw_pkg::DATA_W-1:0] integ_s2;
	logic signed [DIFF_W-1:0]            diff_s2;
	logic                                en_s2;

	// Stage 3: gain products.
	logic signed [PP_W-1:0]             prod_p_s3;
	logic signed [PI_W-1:0]             prod_i_s3;
	logic signed [PD_W-1:0]             prod_d_s3;
	logic signed [pidaw_pkg::ERR_W-1:0] err_s3;
	logic                               en_s3;

	// Output register.
	logic signed [pidaw_pkg::DATA_W-1:0] drive_q;
	logic signed [pidaw_pkg::ERR_W-1:0]  err_q;
	logic                                not_ready_q;

	logic signed [SUM_W-1:0]            sum;
	logic signed [SH_W-1:0]             shifted;
	logic signed [SH_W-1:0]             ceil_w, floor_w, limited;
	logic signed [pidaw_pkg::DATA_W-1:0] drive_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
			if (adv_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			meas_s1 <= measurement;
		end
		if (step_s1) begin
			err_s2   <= err;
			integ_s2 <= integ_clamped[pidaw_pkg::DATA_W-1:0];
			diff_s2  <= diff;
			en_s2    <= cfg.run_enable;
		end
		if (v_s2 && adv_s3) begin
			prod_p_s3 <= PP_W'(cfg.prop_gain) * PP_W'(err_s2);
			prod_i_s3 <= PI_W'(cfg.integ_gain) * PI_W'(integ_s2);
			prod_d_s3 <= PD_W'(cfg.deriv_gain) * PD_W'(diff_s2);
			err_s3    <= err_s2;
			en_s3     <= en_s2;
		end
		if (v_s3 && adv_out) begin
			drive_q     <= en_s3 ? drive_sat : '0;
			err_q       <= en_s3 ? err_s3 : '0;
			not_ready_q <= !en_s3;
		end
	end

	// Sum of exact products, floor to Q8.8, then ceiling first and floor last.
	always_comb begin
		sum = SUM_W'(prod_p_s3) + SUM_W'(prod_i_s3) + SUM_W'(prod_d_s3);
		shifted = sum[SUM_W-1:pidaw_pkg::FRAC_BITS];
		ceil_w  = SH_W'(cfg.drive_ceiling);
		floor_w = SH_W'(cfg.drive_floor);
		limited = shifted;
		if (limited > ceil_w) begin
			limited = ceil_w;
		end
		if (limited < floor_w) begin
			limited = floor_w;
		end
		drive_sat = limited[pidaw_pkg::DATA_W-1:0];
	end

	assign out_valid     = out_valid_q;
	assign drive         = drive_q;
	assign control_error = err_q;
	assign not_ready     = not_ready_q;

endmodule
`default_nettype wire

// ----- dv/pid_controller_antiwindup_top_test.sv -----
`default_nettype none
module pid_controller_antiwindup_top_test;

	localparam int DATA_W         = pidaw_pkg::DATA_W;
	localparam int ERR_W          = pidaw_pkg::ERR_W;
	localparam int INDEX_W        = pidaw_pkg::INDEX_W;
	localparam int BOUND_W        = pidaw_pkg::BOUND_W;
	localparam int FRAC_BITS      = pidaw_pkg::FRAC_BITS;
	localparam int NUM_REGS       = 8;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_AT        = 150;
	localparam int HOLD_CYCLES    = 60;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_SAMPLES  = 48;
	localparam int DIRECTED_ROWS  = 39;
	localparam int REPORT_LIMIT   = 40;
	localparam logic [INDEX_W-1:0] SPARE_INDEX = 4'd15;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic signed [ERR_W-1:0]  control_error;
		logic                     not_ready;
	} ctrl_result_t;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_SAMPLE,
		ROW_SAMPLE_KNOWN
	} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [INDEX_W-1:0]  index;
		logic [DATA_W-1:0]   value;
		ctrl_result_t        known;
	} stim_row_t;

	localparam ctrl_result_t IDLE_RESULT = '{16'h0000, 17'h00000, 1'b1};
	localparam ctrl_result_t NO_RESULT   = '0;

	// Rows marked ROW_SAMPLE_KNOWN carry results worked out by hand; the rest go
	// through the controller model below.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_SAMPLE_KNOWN, 4'd0, 16'h1234, IDLE_RESULT},
		'{ROW_SAMPLE_KNOWN, 4'd0, 16'h8000, IDLE_RESULT},
		'{ROW_WRITE, pidaw_pkg::REG_RUN_ENABLE, 16'h0001, NO_RESULT},
		'{ROW_SAMPLE_KNOWN, 4'd0, 16'h0000, '{16'h0000, 17'h00000, 1'b0}},
		'{ROW_SAMPLE_KNOWN, 4'd0, 16'h8000, '{16'h6400, 17'h08000, 1'b0}},
		'{ROW_SAMPLE_KNOWN, 4'd0, 16'h7FFF, '{16'h9C00, 17'h18001, 1'b0}},
		'{ROW_WRITE, pidaw_pkg::REG_TARGET, 16'h7FFF, NO_RESULT},
		'{ROW_SAMPLE_KNOWN, 4'd0, 16'h8000, '{16'h6400, 17'h0FFFF, 1'b0}},
		'{ROW_SAMPLE_KNOWN, 4'd0, 16'h7FFF, '{16'h0000, 17'h00000, 1'b0}},
		'{ROW_WRITE, pidaw_pkg::REG_TARGET, 16'h8000, NO_RESULT},
		'{ROW_SAMPLE_KNOWN, 4'd0, 16'h7FFF, '{16'h9C00, 17'h10001, 1'b0}},
		'{ROW_WRITE, pidaw_pkg::REG_PROP_GAIN, 16'h8000, NO_RESULT},
		'{ROW_WRITE, pidaw_pkg::REG_INTEG_GAIN, 16'h7FFF, NO_RESULT},
		'{ROW_WRITE, pidaw_pkg::REG_DERIV_GAIN, 16'h8000, NO_RESULT},
		'{ROW_WRITE, pidaw_pkg::REG_FLOOR, 16'h8000, NO_RESULT},
		'{ROW_WRITE, pidaw_pkg::REG_CEILING, 16'h7FFF, NO_RESULT},
		'{ROW_SAMPLE, 4'd0, 16'h7FFF, NO_RESULT},
		'{ROW_SAMPLE, 4'd0, 16'h8000, NO_RESULT},
		'{ROW_SAMPLE, 4'd0, 16'h0000, NO_RESULT},
		'{ROW_SAMPLE, 4'd0, 16'h1234, NO_RESULT},
		'{ROW_WRITE, pidaw_pkg::REG_WINDUP, 16'h0000, NO_RESULT},
		'{ROW_SAMPLE, 4'd0, 16'h0100, NO_RESULT},
		'{ROW_SAMPLE, 4'd0, 16'hFF00, NO_RESULT},
		'{ROW_WRITE, pidaw_pkg::REG_PROP_GAIN, 16'h0080, NO_RESULT},
		'{ROW_WRITE, pidaw_pkg::REG_INTEG_GAIN, 16'h0040, NO_RESULT},
		'{ROW_WRITE, pidaw_pkg::REG_DERIV_GAIN, 16'h0100, NO_RESULT},
		'{ROW_WRITE, pidaw_pkg::REG_WINDUP, 16'hFFFF, NO_RESULT},
		'{ROW_SAMPLE, 4'd0, 16'h8100, NO_RESULT},
		'{ROW_SAMPLE, 4'd0, 16'h7F00, NO_RESULT},
		'{ROW_SAMPLE, 4'd0, 16'h8100, NO_RESULT},
		'{ROW_WRITE, SPARE_INDEX, 16'h1234, NO_RESULT},
		'{ROW_SAMPLE, 4'd0, 16'h0000, NO_RESULT},
		'{ROW_WRITE, pidaw_pkg::REG_FLOOR, 16'h0064, NO_RESULT},
		'{ROW_WRITE, pidaw_pkg::REG_CEILING, 16'hFF9C, NO_RESULT},
		'{ROW_SAMPLE_KNOWN, 4'd0, 16'h0000, '{16'h0064, 17'h18000, 1'b0}},
		'{ROW_WRITE, pidaw_pkg::REG_RUN_ENABLE, 16'h0000, NO_RESULT},
		'{ROW_SAMPLE_KNOWN, 4'd0, 16'h5555, IDLE_RESULT},
		'{ROW_WRITE, pidaw_pkg::REG_RUN_ENABLE, 16'h0001, NO_RESULT},
		'{ROW_SAMPLE, 4'd0, 16'hAAAA, NO_RESULT}
	};

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [INDEX_W-1:0]          cfg_index;
	logic [DATA_W-1:0]           cfg_data;
	logic                        in_valid;
	logic                        in_ready;
	logic signed [DATA_W-1:0]    measurement;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [DATA_W-1:0]    drive;
	logic signed [ERR_W-1:0]     control_error;
	logic                        not_ready;

	// Controller model state and its copy of the register file.
	logic signed [DATA_W-1:0]    pid_target;
	logic signed [DATA_W-1:0]    pid_kp;
	logic signed [DATA_W-1:0]    pid_ki;
	logic signed [DATA_W-1:0]    pid_kd;
	logic signed [DATA_W-1:0]    pid_floor;
	logic signed [DATA_W-1:0]    pid_ceiling;
	logic [BOUND_W-1:0]          pid_bound;
	logic                        pid_enabled;
	logic signed [DATA_W-1:0]    pid_integral;
	logic signed [ERR_W-1:0]     pid_last_error;

	ctrl_result_t awaited_outputs [$];
	int           mismatches = 0;
	int           delivered = 0;
	int           quiet_cycles = 0;
	bit           steady = 1'b0;

	pid_controller_antiwindup_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.measurement   (measurement),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive         (drive),
		.control_error (control_error),
		.not_ready     (not_ready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic logic [DATA_W-1:0] extreme_word();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'h0001;
		endcase
	endfunction

	function automatic void apply_register_write(logic [INDEX_W-1:0] idx,
			logic [DATA_W-1:0] value);
		if (idx >= NUM_REGS)
			return;
		case (idx)
			pidaw_pkg::REG_TARGET:     pid_target  = value;
			pidaw_pkg::REG_PROP_GAIN:  pid_kp      = value;
			pidaw_pkg::REG_INTEG_GAIN: pid_ki      = value;
			pidaw_pkg::REG_DERIV_GAIN: pid_kd      = value;
			pidaw_pkg::REG_FLOOR:      pid_floor   = value;
			pidaw_pkg::REG_CEILING:    pid_ceiling = value;
			pidaw_pkg::REG_WINDUP:     pid_bound   = value[BOUND_W-1:0];
			default:                   pid_enabled = value[0];
		endcase
		pid_integral   = '0;
		pid_last_error = '0;
	endfunction

	function automatic ctrl_result_t next_control_output(logic signed [DATA_W-1:0] meas);
		ctrl_result_t r;
		longint       err;
		longint       integ;
		longint       sum;
		longint       level;
		if (!pid_enabled)
			return IDLE_RESULT;
		err   = longint'(pid_target) - longint'(meas);
		integ = longint'(pid_integral) + err;
		if (integ > longint'(pid_bound))
			integ = longint'(pid_bound);
		else if (integ < -longint'(pid_bound))
			integ = -longint'(pid_bound);
		sum = longint'(pid_kp) * err + longint'(pid_ki) * integ
			+ longint'(pid_kd) * (err - longint'(pid_last_error));
		// Arithmetic shift of the exact sum rounds toward minus infinity.
		level = sum >>> FRAC_BITS;
		if (level > longint'(pid_ceiling))
			level = longint'(pid_ceiling);
		if (level < longint'(pid_floor))
			level = longint'(pid_floor);
		pid_integral   = integ[DATA_W-1:0];
		pid_last_error = err[ERR_W-1:0];
		r.drive         = level[DATA_W-1:0];
		r.control_error = err[ERR_W-1:0];
		r.not_ready     = 1'b0;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] random_setting(pidaw_pkg::reg_idx_t r);
		int                roll;
		logic [DATA_W-1:0] value;
		roll  = $urandom_range(0, 99);
		value = 16'($urandom);
		case (r)
			pidaw_pkg::REG_TARGET:
				if (roll < 20)
					value = extreme_word();
			pidaw_pkg::REG_PROP_GAIN, pidaw_pkg::REG_INTEG_GAIN, pidaw_pkg::REG_DERIV_GAIN:
				if (roll < 15)
					value = extreme_word();
				else if (roll < 70)
					value = 16'($urandom_range(0, 1024) - 512);
			pidaw_pkg::REG_FLOOR:
				if (roll < 15)
					value = extreme_word();
				else if (roll < 75)
					value = 16'(-int'($urandom_range(0, 32768)));
			pidaw_pkg::REG_CEILING:
				if (roll < 15)
					value = extreme_word();
				else if (roll < 75)
					value = 16'($urandom_range(0, 32767));
			pidaw_pkg::REG_WINDUP:
				if (roll < 15)
					value = 16'h0000;
				else if (roll < 30)
					value = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h7FFF;
				else if (roll < 80)
					value = 16'($urandom_range(0, 4096));
			default:
				value[0] = (roll >= 12);
		endcase
		return value;
	endfunction

	// All driving tasks are entered and left at a falling edge.
	task automatic settle();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (awaited_outputs.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		apply_register_write(idx, value);
		@(negedge clk);
	endtask

	task automatic offer_sample(logic signed [DATA_W-1:0] meas, bit use_known,
			ctrl_result_t known);
		int           gap;
		ctrl_result_t forecast;
		cfg_valid <= 1'b0;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		measurement <= meas;
		do @(posedge clk); while (!in_ready);
		forecast = next_control_output(meas);
		awaited_outputs.push_back(use_known ? known : forecast);
		@(negedge clk);
	endtask

	initial begin
		int roll;
		logic signed [DATA_W-1:0] meas;
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		measurement    = '0;
		pid_target     = pidaw_pkg::TARGET_RST;
		pid_kp         = pidaw_pkg::PROP_GAIN_RST;
		pid_ki         = pidaw_pkg::INTEG_GAIN_RST;
		pid_kd         = pidaw_pkg::DERIV_GAIN_RST;
		pid_floor      = pidaw_pkg::FLOOR_RST;
		pid_ceiling    = pidaw_pkg::CEILING_RST;
		pid_bound      = pidaw_pkg::WINDUP_RST;
		pid_enabled    = 1'b0;
		pid_integral   = '0;
		pid_last_error = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_WRITE: begin
					settle();
					write_reg(directed_rows[i].index, directed_rows[i].value);
				end
				ROW_SAMPLE:
					offer_sample(directed_rows[i].value, 1'b0, NO_RESULT);
				default:
					offer_sample(directed_rows[i].value, 1'b1, directed_rows[i].known);
			endcase
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			steady = ($urandom_range(0, 3) == 0);
			for (int r = 0; r < NUM_REGS - 1; r++)
				if ($urandom_range(0, 1) != 0)
					write_reg(INDEX_W'(r), random_setting(pidaw_pkg::reg_idx_t'(r)));
			if ($urandom_range(0, 4) == 0)
				write_reg(INDEX_W'($urandom_range(NUM_REGS, 15)), 16'($urandom));
			write_reg(pidaw_pkg::REG_RUN_ENABLE,
				random_setting(pidaw_pkg::REG_RUN_ENABLE));
			for (int n = 0; n < PHASE_SAMPLES; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 45)
					meas = pid_target + 16'($urandom_range(0, 1536) - 768);
				else if (roll < 60)
					meas = extreme_word();
				else
					meas = 16'($urandom);
				offer_sample(meas, 1'b0, NO_RESULT);
			end
		end

		settle();
		if (mismatches == 0 && awaited_outputs.size() == 0)
			$display("pid_controller_antiwindup_top: match");
		else
			$display("pid_controller_antiwindup_top: mismatch");
		$finish;
	end

	// Result side: random back-pressure, plus one long hold-off while samples keep
	// coming so that the pipeline fills and in_ready drops.
	initial begin
		int stall_left;
		bit held;
		stall_left = 0;
		held       = 1'b0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && delivered >= HOLD_AT && in_valid) begin
				stall_left = HOLD_CYCLES;
				held       = 1'b1;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		ctrl_result_t want;
		if (arst_n && out_valid && out_ready) begin
			delivered++;
			if (awaited_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected output transaction: drive %0d error %0d not_ready %0b",
						$time, drive, control_error, not_ready);
			end else begin
				want = awaited_outputs.pop_front();
				if (drive !== want.drive || control_error !== want.control_error
						|| not_ready !== want.not_ready) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: expected drive %0d error %0d not_ready %0b, got %0d %0d %0b",
							$time, want.drive, want.control_error, want.not_ready,
							drive, control_error, not_ready);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("pid_controller_antiwindup_top: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
`default_nettype wire
